@@ rtl/isd_pkg.sv @@
// Shared types and constants for the inertial scroll decelerator.
// No dependencies; compile first.
package isd_pkg;

   // Serial divider geometry: speed squared over 2^17 needs 47 bits,
   // and a divisor never exceeds the 20-bit keep-speed distance.
   localparam int DIV_NUM_W = 47;
   localparam int DIV_DEN_W = 20;
   localparam int DIV_CNT_W = 6;

   localparam logic [DIV_CNT_W-1:0] WHEEL_STEPS = 6'd16;
   localparam logic [DIV_CNT_W-1:0] DECEL_STEPS = 6'd47;

   localparam int CSR_DATA_W = 20;

   typedef enum logic [1:0] {
      CMD_WHEEL = 2'd0,
      CMD_TICK  = 2'd1,
      CMD_STOP  = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      CSR_WHEEL_UNIT    = 2'd0,
      CSR_DIST_PER_NTCH = 2'd1,
      CSR_START_SPEED   = 2'd2,
      CSR_KEEP_DIST     = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_CNT_W-1:0] steps;
      logic [DIV_NUM_W-1:0] dividend;
      logic [DIV_DEN_W-1:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic                 busy;
      logic                 done;
      logic [DIV_NUM_W-1:0] quotient;
   } div_res_type;

endpackage

@@ rtl/isd_if.sv @@
// Valid/ready channel interfaces for the scroll decelerator request and response beats.
// No dependencies.
interface isd_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         command;
   logic signed [15:0] rotation;

   modport source (output valid, command, rotation, input ready);
   modport sink   (input valid, command, rotation, output ready);
endinterface

interface isd_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [10:0] scroll_amount;
   logic               scroll_valid;
   logic               started;
   logic               stopped;
   logic               active;

   modport source (output valid, scroll_amount, scroll_valid, started, stopped, active,
                   input ready);
   modport sink   (input valid, scroll_amount, scroll_valid, started, stopped, active,
                   output ready);
endinterface

@@ rtl/isd_div.sv @@
// Restoring serial divider, one quotient bit per cycle, MSB-first over a step count.
// Depends on isd_pkg.
module isd_div
   import isd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_cmd_type cmd,
   output div_res_type res
);

   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [DIV_NUM_W-1:0] num_ff;
   logic [DIV_NUM_W-1:0] quo_ff;
   logic [DIV_DEN_W-1:0] rem_ff;
   logic [DIV_DEN_W-1:0] den_ff;

   logic [DIV_DEN_W:0]   trial;
   logic [DIV_DEN_W:0]   diff;
   logic                 fits;

   assign trial = {rem_ff, num_ff[DIV_NUM_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == DIV_CNT_W'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         cnt_ff <= cmd.steps;
         num_ff <= cmd.dividend;
         den_ff <= cmd.divisor;
         rem_ff <= '0;
         quo_ff <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - DIV_CNT_W'(1);
         num_ff <= {num_ff[DIV_NUM_W-2:0], 1'b0};
         rem_ff <= fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
         quo_ff <= {quo_ff[DIV_NUM_W-2:0], fits};
      end
   end

   assign res.busy     = busy_ff;
   assign res.done     = done_ff;
   assign res.quotient = quo_ff;

endmodule

@@ rtl/inertial_scroll_decelerator.sv @@
// Top level of the inertial scroll decelerator: sequencer, motion state and result register.
// Depends on isd_pkg, isd_req_if / isd_rsp_if and isd_div.
//
//   channel | dir | handshake             | payload
//   --------+-----+-----------------------+---------------------------------------------
//   req     | in  | req.valid/req.ready   | command, rotation
//   rsp     | out | rsp.valid/rsp.ready   | scroll_amount, scroll_valid, started,
//           |     |                       | stopped, active
//   csr     | in  | csr_we (no back-pressure) | csr_index, csr_wdata
//
// Every request beat produces exactly one response beat. The sequencer works on one item at a time.
// Stop, idle tick, no-op, zero-rotation wheel and tick without a deceleration refresh go
// straight to FIN. A tick that refreshes the deceleration runs DSQ (square), DGO and DDIV
// (47 divider steps), or goes from DSQ to FIN when the distance sits outside the keep-speed
// window. A wheel beat runs WDIV (16 divider steps for notches) and WADD, then the same
// deceleration path. The shared serial divider does both divides. Reset is synchronous and
// clears the sequencer, motion state and response valid, and sets the configuration to defaults;
// there is no clearing pass. A response stalled by rsp.ready holds only the result register:
// the next request beat is taken meanwhile, and its result waits in FIN.
module inertial_scroll_decelerator
   import isd_pkg::*;
#(
   parameter int DISTANCE_BITS = 24
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   isd_req_if.sink               req,
   isd_rsp_if.source             rsp
);

   localparam int CMP_W = (DISTANCE_BITS > DIV_DEN_W) ? DISTANCE_BITS : DIV_DEN_W;
   localparam int PROD_W = 28;
   localparam int SUM_W = ((DISTANCE_BITS > PROD_W) ? DISTANCE_BITS : PROD_W) + 1;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_WDIV = 7'b0000010,
      ST_WADD = 7'b0000100,
      ST_DSQ  = 7'b0001000,
      ST_DGO  = 7'b0010000,
      ST_DDIV = 7'b0100000,
      ST_FIN  = 7'b1000000
   } state_type;

   // configuration
   logic [9:0]  unit_ff;
   logic [11:0] dpn_ff;
   logic [9:0]  sspeed_ff;
   logic [19:0] keep_ff;

   // motion state
   state_type               state_ff, state_in;
   logic [DISTANCE_BITS-1:0] dist_ff, dist_in;
   logic [31:0]             speed_ff, speed_in;
   logic [31:0]             decel_ff, decel_in;
   logic                    down_ff, down_in;
   logic                    running_ff, running_in;
   logic [63:0]             sq_ff, sq_in;

   // per-item result flags, gathered while the item works
   logic [10:0] amt_ff, amt_in;
   logic        sv_ff, sv_in;
   logic        began_ff, began_in;
   logic        ended_ff, ended_in;

   // response register
   logic        out_valid_ff, out_valid_in;
   logic [10:0] out_amt_ff;
   logic        out_sv_ff;
   logic        out_began_ff;
   logic        out_ended_ff;
   logic        out_active_ff;
   logic        out_load;

   div_cmd_type div_cmd;
   div_res_type div_res;

   // helpers
   logic        accept;
   cmd_type     cmd;
   logic        raw_down;
   logic [15:0] mag;
   logic        reversal;
   logic [9:0]  unit_eff;
   logic [15:0] now;
   logic [9:0]  now_clamp;
   logic [10:0] now_signed;
   logic        now_ge_dist;
   logic        dec_ge_speed;
   logic        need_decel;
   logic [PROD_W-1:0] wprod;
   logic [SUM_W-1:0]  wsum;
   logic [63:0] sq_prod;

   isd_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .res   (div_res)
   );

   // Configuration writes; taken only while idle by contract.
   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ff   <= 10'd120;
         dpn_ff    <= 12'd100;
         sspeed_ff <= 10'd30;
         keep_ff   <= 20'd200;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_WHEEL_UNIT:    unit_ff   <= csr_wdata[9:0];
            CSR_DIST_PER_NTCH: dpn_ff    <= csr_wdata[11:0];
            CSR_START_SPEED:   sspeed_ff <= csr_wdata[9:0];
            CSR_KEEP_DIST:     keep_ff   <= csr_wdata[19:0];
            default: ;
         endcase
      end
   end

   assign accept   = req.valid && req.ready;
   assign cmd      = cmd_type'(req.command);
   assign raw_down = req.rotation[15];
   assign mag      = raw_down ? 16'(-req.rotation) : 16'(req.rotation);
   assign reversal = running_ff && (down_ff != raw_down);
   // a zero wheel unit divides as one
   assign unit_eff = (unit_ff == 10'd0) ? 10'd1 : unit_ff;

   // Tick arithmetic: emit the integer part of speed, clamp to ten bits of magnitude.
   assign now          = speed_ff[31:16];
   assign now_clamp    = (now[15:10] != 6'd0) ? 10'h3FF : now[9:0];
   assign now_signed   = down_ff ? {1'b0, now_clamp} : 11'(-{1'b0, now_clamp});
   assign now_ge_dist  = DISTANCE_BITS'(now) >= dist_ff;
   assign dec_ge_speed = decel_ff >= speed_ff;

   // Deceleration is only nonzero inside the keep-speed window and away from zero.
   assign need_decel = !(CMP_W'(dist_ff) > CMP_W'(keep_ff)) && (dist_ff != '0);

   assign wprod   = PROD_W'(div_res.quotient[15:0]) * PROD_W'(dpn_ff);
   assign wsum    = SUM_W'(dist_ff) + SUM_W'(wprod);
   assign sq_prod = 64'(speed_ff) * 64'(speed_ff);

   assign out_load = (state_ff == ST_FIN) && (!out_valid_ff || rsp.ready);

   always_comb begin
      state_in   = state_ff;
      dist_in    = dist_ff;
      speed_in   = speed_ff;
      decel_in   = decel_ff;
      down_in    = down_ff;
      running_in = running_ff;
      sq_in      = sq_ff;
      amt_in     = amt_ff;
      sv_in      = sv_ff;
      began_in   = began_ff;
      ended_in   = ended_ff;

      div_cmd.start    = 1'b0;
      div_cmd.steps    = WHEEL_STEPS;
      div_cmd.dividend = {mag, 31'd0};
      div_cmd.divisor  = DIV_DEN_W'(unit_eff);

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               amt_in   = '0;
               sv_in    = 1'b0;
               began_in = 1'b0;
               ended_in = 1'b0;
               state_in = ST_FIN;
               unique case (cmd)
                  CMD_WHEEL: begin
                     if (req.rotation != 16'sd0) begin
                        // reversal drops the old run first, then the same beat restarts
                        ended_in   = reversal;
                        dist_in    = reversal ? '0 : dist_ff;
                        down_in    = raw_down;
                        speed_in   = {6'd0, sspeed_ff, 16'd0};
                        running_in = 1'b1;
                        began_in   = !running_ff || reversal;
                        div_cmd.start = 1'b1;
                        state_in   = ST_WDIV;
                     end
                  end
                  CMD_TICK: begin
                     if (running_ff) begin
                        sv_in    = 1'b1;
                        amt_in   = now_signed;
                        dist_in  = now_ge_dist ? '0 : dist_ff - DISTANCE_BITS'(now);
                        speed_in = dec_ge_speed ? '0 : speed_ff - decel_ff;
                        if (now_ge_dist || dec_ge_speed) begin
                           dist_in    = '0;
                           speed_in   = '0;
                           decel_in   = '0;
                           down_in    = 1'b1;
                           running_in = 1'b0;
                           ended_in   = 1'b1;
                        end else if (decel_ff == 32'd0) begin
                           state_in = ST_DSQ;
                        end
                     end
                  end
                  CMD_STOP: begin
                     if (running_ff) begin
                        dist_in    = '0;
                        speed_in   = '0;
                        decel_in   = '0;
                        down_in    = 1'b1;
                        running_in = 1'b0;
                        ended_in   = 1'b1;
                     end
                  end
                  CMD_NOP: ;
                  default: ;
               endcase
            end
         end
         ST_WDIV: begin
            if (div_res.done) begin
               state_in = ST_WADD;
            end
         end
         ST_WADD: begin
            // add the notch distance, saturate at all ones
            dist_in  = (wsum[SUM_W-1:DISTANCE_BITS] != '0) ? '1 : wsum[DISTANCE_BITS-1:0];
            state_in = ST_DSQ;
         end
         ST_DSQ: begin
            if (need_decel) begin
               sq_in    = sq_prod;
               state_in = ST_DGO;
            end else begin
               decel_in = '0;
               state_in = ST_FIN;
            end
         end
         ST_DGO: begin
            // v^2 / (s * 2^17): drop the 17 low bits first, then divide by s
            div_cmd.start    = 1'b1;
            div_cmd.steps    = DECEL_STEPS;
            div_cmd.dividend = sq_ff[63:17];
            div_cmd.divisor  = DIV_DEN_W'(dist_ff);
            state_in         = ST_DDIV;
         end
         ST_DDIV: begin
            if (div_res.done) begin
               decel_in = (div_res.quotient[DIV_NUM_W-1:32] != '0) ? 32'hFFFF_FFFF
                                                                   : div_res.quotient[31:0];
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         dist_ff    <= '0;
         speed_ff   <= '0;
         decel_ff   <= '0;
         down_ff    <= 1'b1;
         running_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         dist_ff    <= dist_in;
         speed_ff   <= speed_in;
         decel_ff   <= decel_in;
         down_ff    <= down_in;
         running_ff <= running_in;
      end
   end

   always_ff @(posedge clock) begin
      sq_ff    <= sq_in;
      amt_ff   <= amt_in;
      sv_ff    <= sv_in;
      began_ff <= began_in;
      ended_ff <= ended_in;
   end

   // Response register: load on FIN, hold while rsp is stalled, drop on take.
   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_amt_ff    <= amt_ff;
         out_sv_ff     <= sv_ff;
         out_began_ff  <= began_ff;
         out_ended_ff  <= ended_ff;
         out_active_ff <= running_ff;
      end
   end

   assign req.ready         = (state_ff == ST_IDLE);
   assign rsp.valid         = out_valid_ff;
   assign rsp.scroll_amount = out_amt_ff;
   assign rsp.scroll_valid  = out_sv_ff;
   assign rsp.started       = out_began_ff;
   assign rsp.stopped       = out_ended_ff;
   assign rsp.active        = out_active_ff;

   // The divider only runs while the sequencer waits on it.
   a_div_idle : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE || state_ff == ST_FIN) |-> !div_res.busy)
      else $error("divider busy outside a divide state");

   // An idle run leaves no residual motion behind.
   a_halt_clean : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && !running_ff) |->
         (dist_ff == '0 && speed_ff == '0 && decel_ff == '0))
      else $error("motion state left over without an active run");

   // Every accepted request takes the sequencer out of idle.
   a_accept_busy : assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != ST_IDLE))
      else $error("request accepted without work");

   // No scroll distance without a tick result.
   a_amt_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.scroll_valid) |-> (rsp.scroll_amount == 11'sd0))
      else $error("scroll amount set on a non-tick result");

endmodule
